// ===== design/bsld_pkg.sv =====
// Types and constants shared by the button-stepped LED dimmer.
package bsld_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_APPLY
  } state_e;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_TICK   = 2'd1,
    OP_ADC    = 2'd2,
    OP_WAKE   = 2'd3
  } op_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TOP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_PERIOD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd7;

  localparam logic [7:0]  RST_NORMAL_TOP     = 8'h05;
  localparam logic [7:0]  RST_LOW_TOP        = 8'h20;
  localparam logic [14:0] RST_LOW_LIMIT      = 15'd229;
  localparam logic [15:0] RST_PRESS_PERIOD   = 16'd20;
  localparam logic [15:0] RST_RELEASE_PERIOD = 16'd25;
  localparam logic [15:0] RST_REFRESH_PERIOD = 16'd5;
  localparam logic [15:0] RST_BATTERY_PERIOD = 16'd225;
  localparam logic [15:0] RST_TIMEOUT        = 16'd2250;

  // Battery voltage = VOLT_SCALE / adc; low when below the limit.
  localparam int unsigned PROD_W      = 23;
  localparam logic [PROD_W-1:0] VOLT_SCALE = 23'd23715;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_QUARTER = 3'd1;
  localparam logic [2:0] MODE_HALF    = 3'd2;
  localparam logic [2:0] MODE_3QUART  = 3'd3;
  localparam logic [2:0] MODE_FULL    = 3'd4;

endpackage

// ===== design/button_stepped_led_dimmer_core.sv =====
// Button-stepped LED dimmer: event stream in, PWM settings stream out.
//
// Input channel (s_axis): one event per transaction. tuser carries the opcode
// (button tick, idle tick, ADC sample, pin-change wake); tdata carries the
// button level and the ADC byte. Output channel (m_axis): exactly one result
// per event with duty, PWM top, LED enable, ADC-start pulse, low-battery flag
// and brightness level.
// An event's result reaches m_axis after its acceptance through the bit-serial
// remainder units that test the two sample periods, one counter bit per cycle
// (the ADC threshold test runs on a shift-add multiplier in the same window),
// and then the commit state. One event is in work at a time; a new event is
// accepted only after the previous one has committed.
// The result sits in an output register, so the next event is taken while an
// earlier result still waits; a stalled receiver holds the commit cycle until
// the output register frees up.
// Reset clears mode, latch, flags and counters, loads the register defaults,
// and leaves the LED off with duty 0 and the normal PWM top.
// Configuration writes (cfg_we_i) take effect at once; the user must make them
// only while no event is in work; the block itself does not enforce this.
module button_stepped_led_dimmer_core #(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // fields from bit 0: button_high[0], adc_value[8:1], zero fill
  input  logic [15:0]                    s_axis_tdata,
  // fields from bit 0: opcode[1:0]
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // fields from bit 0: duty[7:0], pwm_top[15:8], led_on[16], adc_start[17],
  // battery_low[18], level[21:19], zero fill
  output logic [23:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [bsld_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bsld_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bsld_pkg::*;

  localparam int unsigned W    = TICK_COUNT_WIDTH;
  localparam int unsigned STEP_W = $clog2(W);
  // timeout compare runs at the wider of counter and register
  localparam int unsigned CMP_W  = (W > 16) ? W : 16;

  // configuration
  logic [7:0]  normal_top_q, low_top_q;
  logic [14:0] low_limit_q;
  logic [15:0] press_per_q, release_per_q, refresh_per_q, battery_per_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_top_q  <= RST_NORMAL_TOP;
      low_top_q     <= RST_LOW_TOP;
      low_limit_q   <= RST_LOW_LIMIT;
      press_per_q   <= RST_PRESS_PERIOD;
      release_per_q <= RST_RELEASE_PERIOD;
      refresh_per_q <= RST_REFRESH_PERIOD;
      battery_per_q <= RST_BATTERY_PERIOD;
      timeout_q     <= RST_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORMAL_TOP:     normal_top_q  <= cfg_wdata_i[7:0];
        CFG_LOW_TOP:        low_top_q     <= cfg_wdata_i[7:0];
        CFG_LOW_LIMIT:      low_limit_q   <= cfg_wdata_i[14:0];
        CFG_PRESS_PERIOD:   press_per_q   <= cfg_wdata_i;
        CFG_RELEASE_PERIOD: release_per_q <= cfg_wdata_i;
        CFG_REFRESH_PERIOD: refresh_per_q <= cfg_wdata_i;
        CFG_BATTERY_PERIOD: battery_per_q <= cfg_wdata_i;
        CFG_TIMEOUT:        timeout_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_fire, out_free, commit;
  logic [STEP_W-1:0] step_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (step_q == '0) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit)             out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // event latch and serial datapath
  op_e         op_q;
  logic        high_q;
  logic [W-1:0] btn_ticks_q, idle_ticks_q, cnt_sr_q, cnt_next;
  logic [15:0] rem_a_q, rem_b_q, rem_a_d, rem_b_d, per_a, per_b;
  logic [7:0]  adc_sr_q;
  logic [PROD_W-1:0] mcand_q, prod_q;

  assign cnt_next = (op_e'(s_axis_tuser) == OP_BUTTON) ? btn_ticks_q + 1'b1
                                                       : idle_ticks_q + 1'b1;
  assign per_a = (op_q == OP_BUTTON) ? press_per_q   : refresh_per_q;
  assign per_b = (op_q == OP_BUTTON) ? release_per_q : battery_per_q;

  // one restoring remainder step per cycle, counter MSB first
  function automatic logic [15:0] rem_step(logic [15:0] rem, logic din, logic [15:0] per);
    logic [16:0] t;
    t = {rem, din};
    if (t >= {1'b0, per}) t = t - {1'b0, per};
    return t[15:0];
  endfunction

  assign rem_a_d = rem_step(rem_a_q, cnt_sr_q[W-1], per_a);
  assign rem_b_d = rem_step(rem_b_q, cnt_sr_q[W-1], per_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_ticks_q  <= '0;
      idle_ticks_q <= '0;
    end else if (in_fire) begin
      unique case (op_e'(s_axis_tuser))
        OP_BUTTON: btn_ticks_q  <= cnt_next;
        OP_TICK:   idle_ticks_q <= cnt_next;
        OP_WAKE:   idle_ticks_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_e'(s_axis_tuser);
      high_q   <= s_axis_tdata[0];
      cnt_sr_q <= cnt_next;
      rem_a_q  <= '0;
      rem_b_q  <= '0;
      step_q   <= STEP_W'(W - 1);
      adc_sr_q <= s_axis_tdata[8:1];
      mcand_q  <= PROD_W'(low_limit_q);
      prod_q   <= '0;
    end else if (state_q == ST_CALC) begin
      cnt_sr_q <= {cnt_sr_q[W-2:0], 1'b0};
      rem_a_q  <= rem_a_d;
      rem_b_q  <= rem_b_d;
      step_q   <= step_q - 1'b1;
      // limit * adc, adc LSB first; adds stop once the byte is shifted out
      if (adc_sr_q[0]) prod_q <= prod_q + mcand_q;
      adc_sr_q <= {1'b0, adc_sr_q[7:1]};
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
    end
  end

  // state update at commit
  logic [2:0] mode_q, mode_d;
  logic       press_q, press_d, low_q, low_d, led_q, led_d, start_d;
  logic [7:0] top_q, top_d, duty_q, duty_d;
  logic       hit_a, hit_b;
  logic [9:0] top_x3;

  assign hit_a = (per_a != '0) && (rem_a_q == '0);
  assign hit_b = (per_b != '0) && (rem_b_q == '0);

  always_comb begin
    mode_d  = mode_q;
    press_d = press_q;
    low_d   = low_q;
    led_d   = led_q;
    top_d   = top_q;
    duty_d  = duty_q;
    start_d = 1'b0;
    top_x3  = '0;
    unique case (op_q)
      OP_BUTTON: begin
        if (hit_a && !high_q) press_d = 1'b1;
        if (hit_b && high_q && press_d) begin
          led_d   = 1'b1;
          mode_d  = mode_q + 1'b1;
          press_d = 1'b0;
        end
      end
      OP_TICK: begin
        if (hit_a && top_d == low_top_q) top_d = normal_top_q;
      end
      OP_ADC: begin
        // floor(S/adc) < L  <=>  S < L*adc; adc of zero gives 0 and reads not low
        low_d = (prod_q > VOLT_SCALE);
      end
      default: ;
    endcase

    // mode stepping or duty refresh from the current mode
    if ((op_q == OP_BUTTON && mode_d != mode_q) || (op_q == OP_TICK && hit_a)) begin
      if (mode_d == MODE_QUARTER) begin
        led_d = 1'b1;
        if (op_q == OP_BUTTON) begin
          start_d = 1'b1;
          top_d   = low_q ? low_top_q : normal_top_q;
        end
        duty_d = {2'b00, top_d[7:2]};
      end else if (mode_d == MODE_HALF) begin
        top_d  = normal_top_q;
        duty_d = {1'b0, normal_top_q[7:1]};
      end else if (mode_d == MODE_3QUART) begin
        top_x3 = {2'b00, top_d} + {1'b0, top_d, 1'b0};
        duty_d = top_x3[9:2];
      end else if (mode_d == MODE_FULL) begin
        duty_d = top_d;
      end else begin
        mode_d = MODE_OFF;
        led_d  = 1'b0;
        duty_d = '0;
      end
    end

    if (op_q == OP_TICK) begin
      if (hit_b) begin
        start_d = 1'b1;
        top_d   = low_q ? low_top_q : normal_top_q;
      end
      if (CMP_W'(idle_ticks_q) > CMP_W'(timeout_q)) begin
        mode_d = MODE_OFF;
        led_d  = 1'b0;
        duty_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      press_q <= 1'b0;
      low_q   <= 1'b0;
      led_q   <= 1'b0;
      top_q   <= RST_NORMAL_TOP;
      duty_q  <= '0;
    end else if (commit) begin
      mode_q  <= mode_d;
      press_q <= press_d;
      low_q   <= low_d;
      led_q   <= led_d;
      top_q   <= top_d;
      duty_q  <= duty_d;
    end
  end

  logic [23:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {2'b00, mode_d, low_d, start_d, led_d, top_d, duty_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_commit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_valid_q && state_q == ST_IDLE))
    else $error("commit did not present a result");

  a_accept_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CALC && !s_axis_tready))
    else $error("accepted event did not start the serial pass");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata[21:19] <= MODE_FULL))
    else $error("brightness level out of range");

  a_mode_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |=> $stable(mode_q))
    else $error("mode changed outside commit");

endmodule
